/* sv/rrqs_pkg.sv */
// shared types and constants for the round-robin quantum scheduler
`timescale 1ns / 1ps

package rrqs_pkg;

	localparam int unsigned MAX_TASKS_DEF = 16;
	localparam logic [15:0] QUANTUM_RST = 16'd4;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] task_id;
		logic [15:0] burst_time;
	} in_item_t;

	typedef struct packed {
		logic [15:0] task_id_res;
		logic [15:0] run_time;
		logic [15:0] time_left;
		logic        finished;
		logic        all_done;
		logic [31:0] elapsed;
		logic        load_rejected;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_t;

endpackage

/* sv/rrqs_ctrl.sv */
// controller state machine: item capture, commit and output valid
`timescale 1ns / 1ps

module rrqs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rrqs_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output rrqs_pkg::ctl_t ctl
);

	rrqs_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrqs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			rrqs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// the unused command is swallowed without a result
				if (in_valid && in_cmd != rrqs_pkg::CMD_NOP) begin
					ctl.capture = 1'b1;
					state_d     = rrqs_pkg::ST_EXEC;
				end
			end
			rrqs_pkg::ST_EXEC: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = rrqs_pkg::ST_IDLE;
				end
			end
			default: state_d = rrqs_pkg::ST_IDLE;
		endcase
	end

	a_commit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> out_valid_q)
		else $error("commit did not raise out_valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || out_ready))
		else $error("commit while output still held");

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == rrqs_pkg::ST_EXEC && !in_ready))
		else $error("capture did not start execution");

endmodule

/* sv/rrqs_dp.sv */
// datapath: task tables, live mask, rotated pick, slice update, output register
`timescale 1ns / 1ps

module rrqs_dp #(
	parameter int unsigned MAX_TASKS = rrqs_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrqs_pkg::ctl_t     ctl,
	input  rrqs_pkg::in_item_t in_data,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	output rrqs_pkg::out_item_t out_data
);

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

	logic [15:0] id_mem   [MAX_TASKS];
	logic [15:0] left_mem [MAX_TASKS];

	logic [15:0]          quantum_q;
	logic [MAX_TASKS-1:0] live_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     next_slot_q;
	logic [31:0]          elapsed_q;

	// captured item and pick
	rrqs_pkg::cmd_t   cmd_q;
	logic [15:0]      tid_q;
	logic [15:0]      burst_q;
	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic [15:0]      rd_id_q;
	logic [15:0]      rd_left_q;

	rrqs_pkg::out_item_t out_q;
	rrqs_pkg::out_item_t out_d;

	logic [MAX_TASKS-1:0] from_start;
	logic [MAX_TASKS-1:0] below_cnt;
	logic [MAX_TASKS-1:0] sel_mask;
	logic [IDX_W-1:0]     pick;
	logic                 pick_found;

	// rotated find-first: first live slot at or above next_slot, else lowest live
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			from_start[i] = (IDX_W'(i) >= next_slot_q);
			below_cnt[i]  = (CNT_W'(i) < count_q);
		end
		sel_mask   = ((live_q & from_start) != '0) ? (live_q & from_start) : live_q;
		pick_found = (live_q != '0);
		pick       = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (sel_mask[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= in_data.cmd;
			tid_q     <= in_data.task_id;
			burst_q   <= in_data.burst_time;
			idx_q     <= pick;
			found_q   <= pick_found;
			rd_id_q   <= id_mem[pick];
			rd_left_q <= left_mem[pick];
		end
	end

	// slice arithmetic
	logic [15:0]          q_eff;
	logic [15:0]          run;
	logic [15:0]          new_left;
	logic [MAX_TASKS-1:0] done_bit;
	logic [MAX_TASKS-1:0] load_bit;
	logic [31:0]          elapsed_step;
	logic                 table_full;
	logic [IDX_W-1:0]     load_idx;

	always_comb begin
		q_eff        = (quantum_q == '0) ? 16'd1 : quantum_q;
		run          = (rd_left_q < q_eff) ? rd_left_q : q_eff;
		new_left     = rd_left_q - run;
		elapsed_step = elapsed_q + {16'd0, run};
		table_full   = (count_q >= CNT_W'(MAX_TASKS));
		load_idx     = count_q[IDX_W-1:0];
		done_bit     = '0;
		load_bit     = '0;
		done_bit[idx_q]    = (new_left == '0);
		load_bit[load_idx] = (burst_q != '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (cmd_q == rrqs_pkg::CMD_LOAD && !table_full) begin
				id_mem[load_idx]   <= tid_q;
				left_mem[load_idx] <= burst_q;
			end else if (cmd_q == rrqs_pkg::CMD_STEP && found_q) begin
				left_mem[idx_q] <= new_left;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= rrqs_pkg::QUANTUM_RST;
			live_q      <= '0;
			count_q     <= '0;
			next_slot_q <= '0;
			elapsed_q   <= '0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_data;
			end
			if (ctl.commit) begin
				unique case (cmd_q)
					rrqs_pkg::CMD_LOAD: begin
						if (!table_full) begin
							live_q  <= live_q | load_bit;
							count_q <= count_q + CNT_W'(1);
						end
					end
					rrqs_pkg::CMD_CLEAR: begin
						live_q      <= '0;
						count_q     <= '0;
						next_slot_q <= '0;
						elapsed_q   <= '0;
					end
					rrqs_pkg::CMD_STEP: begin
						if (found_q) begin
							live_q    <= live_q & ~done_bit;
							elapsed_q <= elapsed_step;
							next_slot_q <= ({1'b0, idx_q} + 1'b1 < (IDX_W + 1)'(count_q))
								? idx_q + IDX_W'(1) : '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// result of the committed transaction
	always_comb begin
		out_d = '0;
		unique case (cmd_q)
			rrqs_pkg::CMD_LOAD: begin
				out_d.load_rejected = table_full;
				out_d.elapsed       = elapsed_q;
			end
			rrqs_pkg::CMD_CLEAR: begin
				out_d.all_done = 1'b1;
			end
			rrqs_pkg::CMD_STEP: begin
				if (found_q) begin
					out_d.task_id_res = rd_id_q;
					out_d.run_time    = run;
					out_d.time_left   = new_left;
					out_d.finished    = (new_left == '0);
					out_d.all_done    = ((live_q & ~done_bit) == '0);
					out_d.elapsed     = elapsed_step;
				end else begin
					out_d.all_done = 1'b1;
					out_d.elapsed  = elapsed_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_q <= out_d;
		end
	end

	assign out_data = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");

	a_live_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q & ~below_cnt) == '0)
		else $error("live slot beyond loaded tasks");

	a_step_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && cmd_q == rrqs_pkg::CMD_STEP && found_q)
			|=> elapsed_q == $past(elapsed_step))
		else $error("elapsed not advanced by the slice");

endmodule

/* sv/round_robin_quantum_scheduler_core.sv */
// top level of the round-robin quantum scheduler
//
//  channel  dir  handshake                payload
//  in       in   in_valid / in_ready      in_data  (cmd, task_id, burst_time)
//  out      out  out_valid / out_ready    out_data (slice result)
//  cfg      in   cfg_valid / cfg_ready    cfg_data (quantum)
//
// every item goes through a capture with the rotated pick and table read,
// then a commit with the read-modify-write of the remaining-time table
// commit waits for the output register to be free; a stalled output holds it there
// reset clears the controller, count, live mask, pointer and elapsed; tables need no clearing
// cfg is always ready; the unused command code is taken without a result
`timescale 1ns / 1ps

module round_robin_quantum_scheduler_core #(
	parameter int unsigned MAX_TASKS = rrqs_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrqs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rrqs_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	rrqs_pkg::ctl_t ctl;

	assign cfg_ready = 1'b1;

	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	rrqs_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule
